FILE: hw/rtl/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types, codes and defaults for the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int MSG_LEN_BITS_DEF   = 16;
    localparam int ARG_COUNT_BITS_DEF = 12;

    localparam int MAX_LEN_W  = 16;   // max_message_len register
    localparam int MAX_ARGS_W = 12;   // max_arguments register
    localparam int ARG_IDX_W  = 12;   // arg_index / arg_count result fields
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int unsigned HDR_BYTES = 4;

    localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RST  = 16'd4096;
    localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RST = 12'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG_LEN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS    = 4'd1;

    localparam logic [1:0] KIND_ARG_BYTE = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_ACCEPT   = 2'd2;
    localparam logic [1:0] KIND_REJECT   = 2'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd1;
    localparam logic [2:0] ERR_SHORT_BODY = 3'd2;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd3;
    localparam logic [2:0] ERR_SIZE_PAST  = 3'd4;
    localparam logic [2:0] ERR_STR_PAST   = 3'd5;
    localparam logic [2:0] ERR_TRAILING   = 3'd6;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           data_byte;
        logic [ARG_IDX_W-1:0] arg_index;
        logic                 arg_last;
        logic [ARG_IDX_W-1:0] arg_count;
        logic [2:0]           error_code;
        logic                 last_of_run;
    } t_result;

    // Results produced by one accepted byte: n of them, r0 first.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_res(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [ARG_IDX_W-1:0] idx, input logic last,
                                       input logic [ARG_IDX_W-1:0] count,
                                       input logic [2:0] err);
        t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.arg_index   = idx;
        r.arg_last    = last;
        r.arg_count   = count;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

FILE: hw/rtl/length_prefixed_request_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_unit
// Splits a byte stream of length-prefixed requests into argument bytes,
// empty-argument markers and accept / reject reports.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  input   | in        | i_in_valid  / o_in_ready    | i_rx_byte
//  result  | out       | o_out_valid / i_out_ready   | o_kind .. o_last_of_run
//  config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One byte a cycle is accepted; each byte is decoded in the cycle it is taken.
//  A byte yields up to two results, queued in a four-entry result queue that
//  drains one a cycle on i_out_ready, so o_in_ready drops while fewer than two
//  slots are free. Synchronous active-low reset; config writes are always taken.
//  A reject closes the stream: later bytes are accepted and dropped until reset.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_unit import lprd_pkg::*; #(
    parameter int MSG_LEN_BITS   = MSG_LEN_BITS_DEF,
    parameter int ARG_COUNT_BITS = ARG_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_data_byte,
    output logic [ARG_IDX_W-1:0]  o_arg_index,
    output logic                  o_arg_last,
    output logic [ARG_IDX_W-1:0]  o_arg_count,
    output logic [2:0]            o_error_code,
    output logic                  o_last_of_run,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [MAX_LEN_W-1:0]  r_max_len;
    logic [MAX_ARGS_W-1:0] r_max_args;
    logic                  accept;
    t_push                 push;
    t_result               res;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_LEN_RST;
            r_max_args <= MAX_ARGS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_MSG_LEN: r_max_len  <= i_cfg_data[MAX_LEN_W-1:0];
                REG_MAX_ARGS:    r_max_args <= i_cfg_data[MAX_ARGS_W-1:0];
                default: ;   // unknown register: ignored
            endcase
        end
    end

    lprd_parser #(
        .MSG_LEN_BITS   (MSG_LEN_BITS),
        .ARG_COUNT_BITS (ARG_COUNT_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .i_max_len  (r_max_len),
        .i_max_args (r_max_args),
        .o_push     (push)
    );

    lprd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_kind        = res.kind;
    assign o_data_byte   = res.data_byte;
    assign o_arg_index   = res.arg_index;
    assign o_arg_last    = res.arg_last;
    assign o_arg_count   = res.arg_count;
    assign o_error_code  = res.error_code;
    assign o_last_of_run = res.last_of_run;

endmodule

FILE: hw/rtl/lprd_parser.sv
// ----------------------------------------------------------------------------
// lprd_parser
// Frame parser state and per-byte decode; emits up to two results per byte.
// ----------------------------------------------------------------------------
module lprd_parser import lprd_pkg::*; #(
    parameter int MSG_LEN_BITS   = MSG_LEN_BITS_DEF,
    parameter int ARG_COUNT_BITS = ARG_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic [MAX_LEN_W-1:0]  i_max_len,
    input  logic [MAX_ARGS_W-1:0] i_max_args,
    output t_push                 o_push
);

    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_NARGS = 2'd1;
    localparam logic [1:0] PH_ALEN  = 2'd2;
    localparam logic [1:0] PH_STR   = 2'd3;

    localparam logic [32:0] LEN_MAX = (33'd1 << MSG_LEN_BITS) - 33'd1;
    localparam logic [32:0] CNT_MAX = (33'd1 << ARG_COUNT_BITS) - 33'd1;
    localparam logic [MSG_LEN_BITS-1:0] BODY_HDR = MSG_LEN_BITS'(HDR_BYTES);

    logic [1:0]                r_phase, n_phase;
    logic [23:0]               r_shift, n_shift;
    logic [1:0]                r_fcnt,  n_fcnt;
    logic [MSG_LEN_BITS-1:0]   r_body,  n_body;
    logic [ARG_COUNT_BITS-1:0] r_args,  n_args;
    logic [ARG_COUNT_BITS-1:0] r_cur,   n_cur;
    logic [MSG_LEN_BITS-1:0]   r_str,   n_str;
    logic                      r_closed, n_closed;

    logic [31:0] v;
    logic [32:0] v_ext;
    logic        do_after;
    logic [1:0]  nres;
    t_result     slot [2];

    assign v     = {i_rx_byte, r_shift};
    assign v_ext = {1'b0, v};

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_fcnt   = r_fcnt;
        n_body   = r_body;
        n_args   = r_args;
        n_cur    = r_cur;
        n_str    = r_str;
        n_closed = r_closed;
        do_after = 1'b0;
        nres     = 2'd0;
        slot[0]  = '0;
        slot[1]  = '0;

        if (i_accept && !r_closed) begin
            if (r_phase == PH_STR) begin
                n_body  = r_body - MSG_LEN_BITS'(1);
                n_str   = r_str - MSG_LEN_BITS'(1);
                slot[0] = mk_res(KIND_ARG_BYTE, i_rx_byte, ARG_IDX_W'(r_cur),
                                 (n_str == '0), '0, ERR_NONE);
                nres    = 2'd1;
                if (n_str == '0) begin
                    n_cur    = r_cur + ARG_COUNT_BITS'(1);
                    n_args   = r_args - ARG_COUNT_BITS'(1);
                    do_after = 1'b1;
                end
            end else begin
                n_fcnt = r_fcnt + 2'd1;
                if (r_phase != PH_LEN) begin
                    n_body = r_body - MSG_LEN_BITS'(1);
                end
                if (r_fcnt != 2'd3) begin
                    n_shift = r_shift | (24'(i_rx_byte) << {r_fcnt, 3'b000});
                end else begin
                    n_shift = '0;
                    unique case (r_phase)
                        PH_LEN: begin
                            if (v_ext > 33'(i_max_len) || v_ext > LEN_MAX) begin
                                slot[0]  = mk_res(KIND_REJECT, '0, '0, 1'b0, '0, ERR_TOO_LONG);
                                nres     = 2'd1;
                                n_closed = 1'b1;
                            end else if (v < 32'(HDR_BYTES)) begin
                                slot[0]  = mk_res(KIND_REJECT, '0, '0, 1'b0, '0,
                                                  ERR_SHORT_BODY);
                                nres     = 2'd1;
                                n_closed = 1'b1;
                            end else begin
                                n_body  = v[MSG_LEN_BITS-1:0];
                                n_cur   = '0;
                                n_phase = PH_NARGS;
                            end
                        end
                        PH_NARGS: begin
                            if (v_ext > 33'(i_max_args) || v_ext > CNT_MAX) begin
                                slot[0]  = mk_res(KIND_REJECT, '0, '0, 1'b0, '0, ERR_TOO_MANY);
                                nres     = 2'd1;
                                n_closed = 1'b1;
                            end else begin
                                n_args   = v[ARG_COUNT_BITS-1:0];
                                do_after = 1'b1;
                            end
                        end
                        default: begin
                            if (v_ext > 33'(n_body)) begin
                                slot[0]  = mk_res(KIND_REJECT, '0, '0, 1'b0, '0, ERR_STR_PAST);
                                nres     = 2'd1;
                                n_closed = 1'b1;
                            end else if (v == '0) begin
                                slot[0]  = mk_res(KIND_EMPTY, '0, ARG_IDX_W'(r_cur), 1'b1,
                                                  '0, ERR_NONE);
                                nres     = 2'd1;
                                n_cur    = r_cur + ARG_COUNT_BITS'(1);
                                n_args   = r_args - ARG_COUNT_BITS'(1);
                                do_after = 1'b1;
                            end else begin
                                n_str   = v[MSG_LEN_BITS-1:0];
                                n_phase = PH_STR;
                            end
                        end
                    endcase
                end
            end

            // argument list advanced: request end, next length field, or error
            if (do_after) begin
                if (n_args == '0) begin
                    if (n_body == '0) begin
                        slot[nres[0]] = mk_res(KIND_ACCEPT, '0, '0, 1'b0,
                                               ARG_IDX_W'(n_cur), ERR_NONE);
                        n_phase = PH_LEN;
                    end else begin
                        slot[nres[0]] = mk_res(KIND_REJECT, '0, '0, 1'b0, '0, ERR_TRAILING);
                        n_closed = 1'b1;
                    end
                    nres = nres + 2'd1;
                end else if (n_body < BODY_HDR) begin
                    slot[nres[0]] = mk_res(KIND_REJECT, '0, '0, 1'b0, '0, ERR_SIZE_PAST);
                    n_closed = 1'b1;
                    nres     = nres + 2'd1;
                end else begin
                    n_phase = PH_ALEN;
                end
            end

            if (nres == 2'd1) begin
                slot[0].last_of_run = 1'b1;
            end else if (nres == 2'd2) begin
                slot[1].last_of_run = 1'b1;
            end
        end
    end

    assign o_push.n  = nres;
    assign o_push.r0 = slot[0];
    assign o_push.r1 = slot[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN;
            r_shift  <= '0;
            r_fcnt   <= '0;
            r_body   <= '0;
            r_args   <= '0;
            r_cur    <= '0;
            r_str    <= '0;
            r_closed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_fcnt   <= n_fcnt;
            r_body   <= n_body;
            r_args   <= n_args;
            r_cur    <= n_cur;
            r_str    <= n_str;
            r_closed <= n_closed;
        end
    end

    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |-> o_push.n == 2'd0)
        else $error("result produced on a closed stream");

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("stream reopened without reset");

    a_second_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n == 2'd2 |-> (o_push.r0.arg_last &&
        (o_push.r1.kind == KIND_ACCEPT || o_push.r1.kind == KIND_REJECT)))
        else $error("second result does not follow an argument end");

endmodule

FILE: hw/rtl/lprd_res_fifo.sv
// ----------------------------------------------------------------------------
// lprd_res_fifo
// Four-entry result queue; takes up to two a cycle, gives one on i_ready.
// ----------------------------------------------------------------------------
module lprd_res_fifo import lprd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_space = (r_cnt <= 3'd2);
    assign o_res   = r_mem[r_rd];
    assign n_cnt   = r_cnt + {1'b0, i_push.n} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push.n;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> r_cnt <= 3'd2)
        else $error("results pushed without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_cnt[1:0])
        else $error("queue pointers disagree with count");

endmodule

FILE: test/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, result and config channels of the request deframer,
// decodes each accepted byte with its own copy of the parser state and limits,
// and compares every accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module deframer_checker import lprd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_data_byte,
    input  logic [ARG_IDX_W-1:0]  i_arg_index,
    input  logic                  i_arg_last,
    input  logic [ARG_IDX_W-1:0]  i_arg_count,
    input  logic [2:0]            i_error_code,
    input  logic                  i_last_of_run,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int LEN_W = MSG_LEN_BITS_DEF;
    localparam int CNT_W = ARG_COUNT_BITS_DEF;

    typedef enum logic [1:0] {
        AWAIT_LENGTH,
        AWAIT_COUNT,
        AWAIT_ARG_LEN,
        IN_STRING
    } t_parse_phase;

    t_parse_phase          phase;
    logic [31:0]           field_acc;
    logic [1:0]            field_pos;
    logic [LEN_W-1:0]      body_left;
    logic [CNT_W-1:0]      args_left;
    logic [CNT_W-1:0]      arg_no;
    logic [LEN_W-1:0]      str_left;
    logic                  closed;
    logic [MAX_LEN_W-1:0]  lim_len;
    logic [MAX_ARGS_W-1:0] lim_args;

    t_result predicted_results [$];
    t_result run_res [2];
    int      run_len;
    int      fail_count = 0;

    task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                        input logic [ARG_IDX_W-1:0] idx, input logic last,
                        input logic [ARG_IDX_W-1:0] count, input logic [2:0] err);
        t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.arg_index   = idx;
        r.arg_last    = last;
        r.arg_count   = count;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        run_res[run_len] = r;
        run_len++;
    endtask

    task automatic reject(input logic [2:0] err);
        closed = 1'b1;
        emit(KIND_REJECT, 8'd0, '0, 1'b0, '0, err);
    endtask

    // what follows once the argument list has moved on
    task automatic settle_list();
        if (args_left == '0) begin
            if (body_left == '0) begin
                phase = AWAIT_LENGTH;
                emit(KIND_ACCEPT, 8'd0, '0, 1'b0, arg_no, ERR_NONE);
            end else begin
                reject(ERR_TRAILING);
            end
        end else if (body_left < LEN_W'(HDR_BYTES)) begin
            reject(ERR_SIZE_PAST);
        end else begin
            phase = AWAIT_ARG_LEN;
        end
    endtask

    task automatic step_arg();
        arg_no    = arg_no + 1'b1;
        args_left = args_left - 1'b1;
        settle_list();
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [31:0] v;
        t_result     r;
        run_len = 0;
        if (!closed) begin
            if (phase == IN_STRING) begin
                body_left = body_left - 1'b1;
                str_left  = str_left - 1'b1;
                emit(KIND_ARG_BYTE, b, arg_no, str_left == '0, '0, ERR_NONE);
                if (str_left == '0)
                    step_arg();
            end else begin
                field_acc = field_acc | (32'(b) << (8 * field_pos));
                field_pos = field_pos + 2'd1;
                // the length word itself is not part of the body
                if (phase != AWAIT_LENGTH)
                    body_left = body_left - 1'b1;
                if (field_pos == 2'd0) begin
                    v         = field_acc;
                    field_acc = '0;
                    case (phase)
                        AWAIT_LENGTH: begin
                            if (v > 32'(lim_len) || (v >> LEN_W) != 0) begin
                                reject(ERR_TOO_LONG);
                            end else if (v < HDR_BYTES) begin
                                reject(ERR_SHORT_BODY);
                            end else begin
                                body_left = v[LEN_W-1:0];
                                arg_no    = '0;
                                phase     = AWAIT_COUNT;
                            end
                        end
                        AWAIT_COUNT: begin
                            if (v > 32'(lim_args) || (v >> CNT_W) != 0) begin
                                reject(ERR_TOO_MANY);
                            end else begin
                                args_left = v[CNT_W-1:0];
                                settle_list();
                            end
                        end
                        default: begin
                            if (v > 32'(body_left)) begin
                                reject(ERR_STR_PAST);
                            end else if (v == 0) begin
                                emit(KIND_EMPTY, 8'd0, arg_no, 1'b1, '0, ERR_NONE);
                                step_arg();
                            end else begin
                                str_left = v[LEN_W-1:0];
                                phase    = IN_STRING;
                            end
                        end
                    endcase
                end
            end
        end
        for (int i = 0; i < run_len; i++) begin
            r             = run_res[i];
            r.last_of_run = (i == run_len - 1);
            predicted_results.insert(predicted_results.size(), r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (predicted_results.size() == 0) begin
            $display("%0t: unexpected result: kind %0d data %0d index %0d err %0d",
                     $time, i_kind, i_data_byte, i_arg_index, i_error_code);
            fail_count++;
        end else begin
            want = predicted_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(i_kind));
            check_field("data_byte", 16'(want.data_byte), 16'(i_data_byte));
            check_field("arg_index", 16'(want.arg_index), 16'(i_arg_index));
            check_field("arg_last", 16'(want.arg_last), 16'(i_arg_last));
            check_field("arg_count", 16'(want.arg_count), 16'(i_arg_count));
            check_field("error_code", 16'(want.error_code), 16'(i_error_code));
            check_field("last_of_run", 16'(want.last_of_run), 16'(i_last_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = AWAIT_LENGTH;
            field_acc = '0;
            field_pos = '0;
            body_left = '0;
            args_left = '0;
            arg_no    = '0;
            str_left  = '0;
            closed    = 1'b0;
            lim_len   = MAX_LEN_RST;
            lim_args  = MAX_ARGS_RST;
            predicted_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MAX_MSG_LEN)
                    lim_len = i_cfg_data[MAX_LEN_W-1:0];
                else if (i_cfg_index == REG_MAX_ARGS)
                    lim_args = i_cfg_data[MAX_ARGS_W-1:0];
            end
            // new predictions go in before the oldest is compared
            if (i_in_valid && i_in_ready)
                deframe_byte(i_rx_byte);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        o_pending    <= predicted_results.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives framed byte streams into the request deframer under bursty input and
// a stalling result side, across several limit settings, and finishes with
// one malformed request that closes the stream. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb;
    import lprd_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic [7:0]            rx_byte      = 8'd0;
    logic                  out_ready    = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  hold_request = 1'b0;

    logic                 in_ready;
    logic                 out_valid;
    logic [1:0]           kind;
    logic [7:0]           data_byte;
    logic [ARG_IDX_W-1:0] arg_index;
    logic                 arg_last;
    logic [ARG_IDX_W-1:0] arg_count;
    logic [2:0]           error_code;
    logic                 last_of_run;
    logic                 cfg_ready;

    int fail_count;
    int pending;

    logic [7:0] tx_bytes [$];
    int         bytes_sent = 0;
    int         burst_left = 0;

    length_prefixed_request_deframer_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_kind        (kind),
        .o_data_byte   (data_byte),
        .o_arg_index   (arg_index),
        .o_arg_last    (arg_last),
        .o_arg_count   (arg_count),
        .o_error_code  (error_code),
        .o_last_of_run (last_of_run),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    deframer_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_rx_byte     (rx_byte),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_kind        (kind),
        .i_data_byte   (data_byte),
        .i_arg_index   (arg_index),
        .i_arg_last    (arg_last),
        .i_arg_count   (arg_count),
        .i_error_code  (error_code),
        .i_last_of_run (last_of_run),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            queue_byte(w[8*i +: 8]);
    endtask

    // one byte per handshake; bursts of random length, mostly with gaps between
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic flush_tx();
        while (tx_bytes.size() != 0)
            send_byte(tx_bytes.pop_front());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // bytes that give no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // well-formed requests with random content, kept within the given limits
    task automatic send_random_requests(input int n_bytes, input int arg_cap,
                                        input int body_cap, input int len_cap);
        int lens [$];
        int target, room, n_args, len, body;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            lens.delete();
            n_args = $urandom_range(0, arg_cap);
            room   = body_cap - HDR_BYTES;
            body   = HDR_BYTES;
            for (int k = 0; k < n_args && room >= 4; k++) begin
                len = $urandom_range(0, (room - 4 < len_cap) ? room - 4 : len_cap);
                // now and then the last argument fills the body up to the limit
                if (k == n_args - 1 && $urandom_range(0, 7) == 0 && room - 4 <= 600)
                    len = room - 4;
                lens.insert(lens.size(), len);
                room -= 4 + len;
                body += 4 + len;
            end
            put_word(body);
            put_word(lens.size());
            foreach (lens[i]) begin
                put_word(lens[i]);
                repeat (lens[i]) queue_byte(8'($urandom_range(0, 255)));
            end
            flush_tx();
        end
    endtask

    initial begin : rx_side
        int mode, stretch;
        bit held;
        held = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            repeat (stretch) begin
                if (hold_request && !held) begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 9) == 0);
                    default: out_ready <= ~out_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [MAX_LEN_W-1:0]  lim_len;
        logic [MAX_ARGS_W-1:0] lim_args;
        logic [2:0]            err_pick;
        logic [31:0]           w;
        int                    variant, extra;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: empty request, then an empty argument and a 0x00 0xFF argument
        put_word(HDR_BYTES);
        put_word(0);
        put_word(HDR_BYTES + 4 + 4 + 2);
        put_word(2);
        put_word(0);
        put_word(2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        flush_tx();
        send_random_requests(300, 6, MAX_LEN_RST, 24);
        wait_drained();

        // widest limits, plus a write to an index outside the map
        write_reg(REG_MAX_MSG_LEN, 16'hFFFF);
        write_reg(REG_MAX_ARGS, CFG_DATA_W'(12'hFFF));
        write_reg(REG_MAX_ARGS + CFG_IDX_W'($urandom_range(1, 14)), CFG_DATA_W'($urandom));
        hold_request <= 1'b1;
        send_random_requests(200, 8, 65535, 40);
        put_word(HDR_BYTES + 4 + 300);
        put_word(1);
        put_word(300);
        repeat (300) queue_byte(8'($urandom_range(0, 255)));
        flush_tx();
        wait_drained();
        put_word(HDR_BYTES + 4 * 40);
        put_word(40);
        repeat (40) put_word(0);
        flush_tx();
        wait_drained();

        // narrowest limits: only empty requests fit
        write_reg(REG_MAX_MSG_LEN, CFG_DATA_W'(HDR_BYTES));
        write_reg(REG_MAX_ARGS, '0);
        repeat (20) begin
            put_word(HDR_BYTES);
            put_word(0);
        end
        flush_tx();
        wait_drained();

        // mid-range limits, junk in the unused top bits of the count limit
        lim_len  = MAX_LEN_W'($urandom_range(64, 600));
        lim_args = MAX_ARGS_W'($urandom_range(2, 20));
        write_reg(REG_MAX_MSG_LEN, lim_len);
        write_reg(REG_MAX_ARGS, {4'($urandom), lim_args});
        send_random_requests(300, lim_args, lim_len, 16);
        wait_drained();

        // one malformed request closes the stream; the noise after it is dropped
        err_pick = 3'($urandom_range(ERR_TOO_LONG, ERR_TRAILING));
        variant  = $urandom_range(0, 2);
        extra    = $urandom_range(1, 8);
        case (err_pick)
            ERR_TOO_LONG: begin
                w = $urandom;
                if (w <= 32'(lim_len))
                    w = 32'(lim_len) + 32'd1;
                put_word(w);
            end
            ERR_SHORT_BODY: put_word($urandom_range(0, HDR_BYTES - 1));
            ERR_TOO_MANY: begin
                put_word($urandom_range(8, lim_len));
                w = $urandom;
                if (w <= 32'(lim_args))
                    w = 32'(lim_args) + 32'd1;
                put_word(w);
            end
            ERR_SIZE_PAST: begin
                if (variant == 0) begin
                    put_word(HDR_BYTES);
                    put_word(1);
                end else begin
                    // after the first argument's last byte the body is too short for another length word
                    put_word(HDR_BYTES + 4 + 2 + 2);
                    put_word(2);
                    put_word(2);
                    repeat (2) queue_byte(8'($urandom));
                end
            end
            ERR_STR_PAST: begin
                put_word(HDR_BYTES + 4 + 2);
                put_word(1);
                put_word($urandom_range(3, 65535));
            end
            ERR_TRAILING: begin
                if (variant == 0) begin
                    put_word(HDR_BYTES + extra);
                    put_word(0);
                end else if (variant == 1) begin
                    put_word(HDR_BYTES + 4 + 1 + extra);
                    put_word(1);
                    put_word(1);
                    queue_byte(8'($urandom));
                end else begin
                    put_word(HDR_BYTES + 4 + extra);
                    put_word(1);
                    put_word(0);
                end
            end
            default: put_word(0);
        endcase
        repeat (30) queue_byte(8'($urandom));
        flush_tx();
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
